// ===== rtl/crc_generate_and_check_macros.svh =====
// ----------------------------------------------------------------------------
// CRC generate and check: assertion macros
// Concurrent assertion shorthands clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC_GENERATE_AND_CHECK_MACROS_SVH
`define CRC_GENERATE_AND_CHECK_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define CRC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/crc_gc_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check: shared package
// Widths, register and job codes, and the single division step.
// ----------------------------------------------------------------------------
package crc_gc_pkg;

	localparam int MAX_DEGREE = 16;
	localparam int DEG_W      = 5;
	localparam int IDX_W      = $clog2(MAX_DEGREE);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLY_TAPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 2'd2;

	localparam logic [MAX_DEGREE-1:0] POLY_TAPS_RST  = 16'h8005;
	localparam logic [DEG_W-1:0]      DEGREE_RST     = 5'd16;
	localparam logic                  CHECK_MODE_RST = 1'b0;

	// Job kinds passed from front to back
	localparam logic [1:0] JOB_ECHO    = 2'd0;
	localparam logic [1:0] JOB_FLUSH   = 2'd1;
	localparam logic [1:0] JOB_VERDICT = 2'd2;

	typedef struct packed {
		logic [MAX_DEGREE-1:0] taps;
		logic [DEG_W-1:0]      deg;
		logic                  check_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic                  data_bit;
		logic [MAX_DEGREE-1:0] rem;
	} job_t;

	function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] raw);
		logic [DEG_W-1:0] d;
		d = raw;
		if (raw == '0)
			d = DEG_W'(1);
		else if (raw > DEG_W'(MAX_DEGREE))
			d = DEG_W'(MAX_DEGREE);
		return d;
	endfunction

	function automatic logic [MAX_DEGREE-1:0] deg_mask(input logic [DEG_W-1:0] d);
		logic [MAX_DEGREE-1:0] m;
		for (int i = 0; i < MAX_DEGREE; i++)
			m[i] = (i < int'(d));
		return m;
	endfunction

	function automatic logic [IDX_W-1:0] top_idx(input logic [DEG_W-1:0] d);
		logic [DEG_W-1:0] dm1;
		dm1 = d - DEG_W'(1);
		return dm1[IDX_W-1:0];
	endfunction

	// Shift one bit in, reduce by the generator when the top bit falls out.
	function automatic logic [MAX_DEGREE-1:0] div_step(
		input logic [MAX_DEGREE-1:0] rem,
		input logic                  din,
		input cfg_t                  c
	);
		logic [MAX_DEGREE-1:0] m;
		logic [MAX_DEGREE-1:0] r;
		logic                  top;
		m   = deg_mask(c.deg);
		top = rem[top_idx(c.deg)];
		r   = {rem[MAX_DEGREE-2:0], din} & m;
		if (top)
			r = r ^ (c.taps & m);
		return r;
	endfunction

endpackage

// ===== rtl/crc_gc_front.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check: front end
// Accepts bits, runs one division step per bit and classifies the job.
// ----------------------------------------------------------------------------
module crc_gc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  crc_gc_pkg::cfg_t                    cfg,
	input  logic                                accept,
	input  logic                                data_bit,
	input  logic                                last_in,
	output logic                                job_valid,
	output crc_gc_pkg::job_t                    job
);
	import crc_gc_pkg::*;

	logic [MAX_DEGREE-1:0] rem_q;
	logic [MAX_DEGREE-1:0] rem_next;

	assign rem_next = div_step(rem_q, data_bit, cfg);

	always_comb begin
		job.data_bit = data_bit;
		job.rem      = rem_next;
		if (cfg.check_mode) begin
			job.kind  = JOB_VERDICT;
			job_valid = accept && last_in;
		end else begin
			job.kind  = last_in ? JOB_FLUSH : JOB_ECHO;
			job_valid = accept;
		end
	end

	// Restart the division after the final bit of every message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= last_in ? '0 : rem_next;
		end
	end

endmodule

// ===== rtl/crc_gc_queue.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check: job queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module crc_gc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  crc_gc_pkg::job_t wr_job,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_en,
	output crc_gc_pkg::job_t rd_job
);
	import crc_gc_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= !wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= !rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/crc_gc_back.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check: back end
// Emits echoes and verdicts, pads and shifts out check bits.
// ----------------------------------------------------------------------------
module crc_gc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  crc_gc_pkg::cfg_t cfg,
	input  logic             job_valid,
	input  crc_gc_pkg::job_t job,
	output logic             job_take,
	output logic             empty,
	input  logic             pop,
	output logic             out_bit,
	output logic             is_check_bit,
	output logic             error_found,
	output logic             last_out
);
	import crc_gc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [MAX_DEGREE-1:0] work_q;
	logic [IDX_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic                  out_bit_q;
	logic                  out_chk_q;
	logic                  out_err_q;
	logic                  out_last_q;
	logic                  slot_free;
	logic                  emit;
	logic [IDX_W-1:0]      tidx;

	assign tidx      = top_idx(cfg.deg);
	assign slot_free = !out_valid_q || pop;
	assign job_take  = (state_q == ST_IDLE) && job_valid && slot_free;
	assign emit      = (state_q == ST_EMIT) && slot_free;

	assign empty        = !out_valid_q;
	assign out_bit      = out_bit_q;
	assign is_check_bit = out_chk_q;
	assign error_found  = out_err_q;
	assign last_out     = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take || emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_take && job.kind == JOB_FLUSH) begin
						state_q <= ST_PAD;
						cnt_q   <= '0;
					end
				end
				ST_PAD: begin
					if (cnt_q == tidx) begin
						state_q <= ST_EMIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit) begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (cnt_q == tidx)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload: work remainder and the output slot.
	always_ff @(posedge clk) begin
		if (job_take) begin
			work_q     <= job.rem;
			out_chk_q  <= 1'b0;
			out_bit_q  <= (job.kind == JOB_VERDICT) ? 1'b0 : job.data_bit;
			out_err_q  <= (job.kind == JOB_VERDICT) ? (|job.rem) : 1'b0;
			out_last_q <= (job.kind == JOB_VERDICT);
		end else if (state_q == ST_PAD) begin
			work_q <= div_step(work_q, 1'b0, cfg);
		end else if (emit) begin
			work_q     <= {work_q[MAX_DEGREE-2:0], 1'b0};
			out_bit_q  <= work_q[tidx];
			out_chk_q  <= 1'b1;
			out_err_q  <= 1'b0;
			out_last_q <= (cnt_q == tidx);
		end
	end

endmodule

// ===== rtl/crc_generate_and_check.sv =====
// ----------------------------------------------------------------------------
// CRC generate and check: top level
// Bit-serial CRC generator and checker with a programmable polynomial.
// ----------------------------------------------------------------------------
// Feed bits most significant first, one item per push, and mark the final bit
// with last_in. The front end runs one division step per accepted bit, so a
// stream of message bits goes in at one item per cycle while full is low, and
// each echo passes through the job queue and the output slot register on its
// way to the result ports. In generate mode the final bit triggers a flush in
// the back end: it echoes the bit, then divides in degree bits of implied zero
// padding, then shifts out degree check bits, one per cycle when pop
// keeps up; the last check bit carries last_out. In check mode only the final
// bit of a codeword yields an item: the verdict, with error_found set when
// the remainder is nonzero. A two-entry job queue sits between front and back,
// so the next message streams in while check bits of the previous one drain,
// until the queue fills; full then holds off the writer. Write poly_taps,
// degree and check_mode only while the block is idle. Degree zero behaves as
// one and degrees above 16 saturate at 16.
module crc_generate_and_check (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [crc_gc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crc_gc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input bits
	input  logic                             push,
	output logic                             full,
	input  logic                             data_bit,
	input  logic                             last_in,
	// results
	output logic                             empty,
	input  logic                             pop,
	output logic                             out_bit,
	output logic                             is_check_bit,
	output logic                             error_found,
	output logic                             last_out
);
	import crc_gc_pkg::*;

	`include "crc_generate_and_check_macros.svh"

	logic [MAX_DEGREE-1:0] poly_taps_q;
	logic [DEG_W-1:0]      degree_q;
	logic                  check_mode_q;
	cfg_t                  cfg;
	logic                  accept;
	logic                  job_valid;
	job_t                  job_in;
	logic                  q_valid;
	logic                  q_take;
	job_t                  job_out;

	// Register writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_taps_q  <= POLY_TAPS_RST;
			degree_q     <= DEGREE_RST;
			check_mode_q <= CHECK_MODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POLY_TAPS:  poly_taps_q  <= cfg_data[MAX_DEGREE-1:0];
				REG_DEGREE:     degree_q     <= cfg_data[DEG_W-1:0];
				REG_CHECK_MODE: check_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the degree once for both halves.
	assign cfg.taps       = poly_taps_q;
	assign cfg.deg        = eff_degree(degree_q);
	assign cfg.check_mode = check_mode_q;

	// Accept a bit only when the queue has room for whatever job it makes.
	assign accept = push && !full;

	crc_gc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.data_bit  (data_bit),
		.last_in   (last_in),
		.job_valid (job_valid),
		.job       (job_in)
	);

	crc_gc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_valid),
		.wr_job   (job_in),
		.full     (full),
		.rd_valid (q_valid),
		.rd_en    (q_take),
		.rd_job   (job_out)
	);

	crc_gc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.job_valid    (q_valid),
		.job          (job_out),
		.job_take     (q_take),
		.empty        (empty),
		.pop          (pop),
		.out_bit      (out_bit),
		.is_check_bit (is_check_bit),
		.error_found  (error_found),
		.last_out     (last_out)
	);

	// A check bit never carries a verdict.
	`CRC_ASSERT_IMPL(a_chk_no_err, !empty && is_check_bit, !error_found, "check bit with error set")
	// A verdict always closes its codeword.
	`CRC_ASSERT_IMPL(a_err_is_last, !empty && error_found, last_out, "verdict not marked last")
	// Inner codeword bits in check mode make no job.
	`CRC_ASSERT_IMPL(a_chk_silent, accept && check_mode_q && !last_in, !job_valid,
		"job made for inner codeword bit")
	// The back end only takes a job that the queue holds.
	`CRC_ASSERT(a_take_valid, !q_take || q_valid, "job taken from empty queue")

endmodule
